>>> rtl/core/swiglu_pkg.sv
// Types, constants and the sigmoid table shared by the SwiGLU activation block.
package swiglu_pkg;

  localparam int DATA_WIDTH = 16;

  // Sigmoid values are unsigned Q0.16, with SIG_ONE standing for 1.0.
  localparam int SIG_FRAC = 16;
  localparam logic [SIG_FRAC:0] SIG_ONE = 17'h10000;

  // The table covers |x| in [0, 8] at a spacing of one quarter.
  localparam int SIG_LAST = 32;
  localparam int SIG_IDX_W = 6;

  localparam int SILU_GUARD = (2 * DATA_WIDTH >= 64) ? 0 :
                              ((64 - 2 * DATA_WIDTH > 8) ? 8 : 64 - 2 * DATA_WIDTH);

  localparam logic [SIG_FRAC-1:0] SIG_TABLE [0:SIG_LAST] = '{
    16'd32768, 16'd36843, 16'd40793, 16'd44511, 16'd47911, 16'd50941, 16'd53581, 16'd55834,
    16'd57724, 16'd59287, 16'd60565, 16'd61598, 16'd62428, 16'd63090, 16'd63615, 16'd64030,
    16'd64357, 16'd64614, 16'd64816, 16'd64974, 16'd65097, 16'd65194, 16'd65269, 16'd65328,
    16'd65374, 16'd65410, 16'd65438, 16'd65459, 16'd65476, 16'd65489, 16'd65500, 16'd65508,
    16'd65514
  };

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] gate_value;
    logic signed [DATA_WIDTH-1:0] up_value;
    logic                         last_element;
  } item_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] activated_value;
    logic                         last_out;
  } result_t;

endpackage

>>> rtl/core/swiglu_activation.sv
// SwiGLU activation: SiLU(gate) times up, in signed fixed point, as a seven-stage pipeline.
//
//   Port group                  Dir  Carries
//   item_valid/item_stall/item  in   gate_value, up_value, last_element
//   result_valid/result_stall/  out  activated_value, last_out
//   result
//
// Each transaction passes through the register stages in turn, and a new transaction may
// enter in every cycle while item_stall is low; the sigmoid table lookup shares a stage with
// the slope multiplier, and the two further multipliers each sit in a stage of their own.
// Reset clears only the stage valid bits. A stall on the result side holds the final stage,
// and empty stages behind it keep filling before item_stall rises.
module swiglu_activation #(
  parameter int FRAC_BITS = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  swiglu_pkg::item_t   item,
  output logic                result_valid,
  input  logic                result_stall,
  output swiglu_pkg::result_t result
);

  localparam int DW      = swiglu_pkg::DATA_WIDTH;
  localparam int SF      = swiglu_pkg::SIG_FRAC;
  localparam int STAGES  = 7;
  localparam int MAG_W   = DW + 1;
  localparam int POS_UP  = (FRAC_BITS <= 18) ? 18 - FRAC_BITS : 0;
  localparam int POS_DN  = (FRAC_BITS > 18) ? FRAC_BITS - 18 : 0;
  localparam int POS_W   = (MAG_W + POS_UP > SF + 7) ? MAG_W + POS_UP : SF + 7;
  localparam int SH1     = SF - swiglu_pkg::SILU_GUARD;
  localparam int SH2     = FRAC_BITS + swiglu_pkg::SILU_GUARD;
  localparam int PROD1_W = DW + SF + 2;
  localparam int SILU_W  = PROD1_W + 1 - SH1;
  localparam int PROD2_W = SILU_W + DW;

  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(swiglu_pkg::SIG_LAST) << SF;
  localparam logic signed [PROD1_W:0] HALF1 = (PROD1_W + 1)'(1) << (SH1 - 1);
  localparam logic signed [PROD2_W:0] HALF2 = (PROD2_W + 1)'(1) << (SH2 - 1);
  localparam logic signed [PROD2_W:0] MAXV = (PROD2_W + 1)'((64'd1 << (DW - 1)) - 64'd1);
  localparam logic signed [PROD2_W:0] MINV = -MAXV - (PROD2_W + 1)'(1);

  typedef enum logic [1:0] {
    MODE_INTERP,
    MODE_END,
    MODE_ONE
  } mode_t;

  logic [STAGES-1:0] valid;
  logic [STAGES:0]   ready;

  always_comb begin
    ready[STAGES] = !result_stall;
    for (int k = STAGES - 1; k >= 0; k--) begin
      ready[k] = !valid[k] || ready[k+1];
    end
  end

  assign item_stall   = !ready[0];
  assign result_valid = valid[STAGES-1];

  // Stage 1: table position from the gate magnitude.
  logic signed [MAG_W-1:0] x_ext;
  logic [MAG_W-1:0]        mag;
  logic [POS_W-1:0]        pos;
  mode_t                   mode_next;

  always_comb begin
    x_ext = {item.gate_value[DW-1], item.gate_value};
    mag   = item.gate_value[DW-1] ? MAG_W'(-x_ext) : MAG_W'(x_ext);
    pos   = (POS_W'(mag) << POS_UP) >> POS_DN;
    if (pos > POS_LIMIT) begin
      mode_next = MODE_ONE;
    end else if (pos[SF+5]) begin
      mode_next = MODE_END;
    end else begin
      mode_next = MODE_INTERP;
    end
  end

  logic signed [DW-1:0] x1, x2, x3;
  logic signed [DW-1:0] u1, u2, u3, u4, u5;
  logic [STAGES-1:0]    last;
  logic                 neg1, neg2;
  mode_t                mode1, mode2;
  logic [4:0]           idx1;
  logic [SF-1:0]        frac1;
  logic [SF-1:0]        lo2;
  logic [2*SF-1:0]      prod2;
  logic [SF:0]          sig3;
  logic signed [PROD1_W-1:0] p4;
  logic signed [SILU_W-1:0]  silu5;
  logic signed [PROD2_W-1:0] p6;
  logic signed [DW-1:0]      res7;

  // Stage 2: table read and slope times fraction.
  logic [SF-1:0] tab_lo;
  logic [SF-1:0] tab_hi;
  logic [SF-1:0] tab_diff;

  always_comb begin
    tab_lo   = swiglu_pkg::SIG_TABLE[{1'b0, idx1}];
    tab_hi   = swiglu_pkg::SIG_TABLE[{1'b0, idx1} + swiglu_pkg::SIG_IDX_W'(1)];
    tab_diff = tab_hi - tab_lo;
  end

  // Stage 3: finish the interpolation and fold in the sign of the gate.
  logic [2*SF:0] prod_round;
  logic [SF:0]   sig_interp;
  logic [SF:0]   sig_pos;
  logic [SF:0]   sig_next;

  always_comb begin
    prod_round = {1'b0, prod2} + (2 * SF + 1)'(1 << (SF - 1));
    sig_interp = {1'b0, lo2} + prod_round[2*SF:SF];
    case (mode2)
      MODE_INTERP: sig_pos = sig_interp;
      MODE_END:    sig_pos = {1'b0, swiglu_pkg::SIG_TABLE[swiglu_pkg::SIG_LAST]};
      MODE_ONE:    sig_pos = swiglu_pkg::SIG_ONE;
      default:     sig_pos = swiglu_pkg::SIG_ONE;
    endcase
    sig_next = neg2 ? swiglu_pkg::SIG_ONE - sig_pos : sig_pos;
  end

  // Stage 4: gate times sigmoid.
  logic signed [SF+1:0] sig_signed;
  assign sig_signed = {1'b0, sig3};

  // Stage 5: round to SiLU with guard bits.
  logic signed [PROD1_W:0] sum1;
  assign sum1 = {p4[PROD1_W-1], p4} + HALF1;

  // Stage 7: round the product and saturate.
  logic signed [PROD2_W:0] sum2;
  logic signed [PROD2_W:0] r_full;
  logic signed [DW-1:0]    res_next;

  always_comb begin
    sum2   = {p6[PROD2_W-1], p6} + HALF2;
    r_full = sum2 >>> SH2;
    if (r_full > MAXV) begin
      res_next = MAXV[DW-1:0];
    end else if (r_full < MINV) begin
      res_next = MINV[DW-1:0];
    end else begin
      res_next = r_full[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (ready[0]) begin
        valid[0] <= item_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (ready[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready[0]) begin
      x1      <= item.gate_value;
      u1      <= item.up_value;
      last[0] <= item.last_element;
      neg1    <= item.gate_value[DW-1];
      mode1   <= mode_next;
      idx1    <= pos[SF+4:SF];
      frac1   <= pos[SF-1:0];
    end
    if (ready[1]) begin
      x2      <= x1;
      u2      <= u1;
      last[1] <= last[0];
      neg2    <= neg1;
      mode2   <= mode1;
      lo2     <= tab_lo;
      prod2   <= tab_diff * frac1;
    end
    if (ready[2]) begin
      x3      <= x2;
      u3      <= u2;
      last[2] <= last[1];
      sig3    <= sig_next;
    end
    if (ready[3]) begin
      u4      <= u3;
      last[3] <= last[2];
      p4      <= x3 * sig_signed;
    end
    if (ready[4]) begin
      u5      <= u4;
      last[4] <= last[3];
      silu5   <= sum1[PROD1_W:SH1];
    end
    if (ready[5]) begin
      last[5] <= last[4];
      p6      <= silu5 * u5;
    end
    if (ready[6]) begin
      last[6] <= last[5];
      res7    <= res_next;
    end
  end

  assign result.activated_value = res7;
  assign result.last_out        = last[STAGES-1];

endmodule
